/* sv/mcr_pkg.sv */
// Shared widths, codes and constants for the midpoint circle rasteriser.
package mcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int STEP_BITS   = RADIUS_BITS + 1;
  localparam int DEC_BITS    = 16;
  localparam int POINT_BITS  = 14;
  localparam int OCT_BITS    = 3;

  localparam int SUM_BITS0 = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS;
  localparam int SUM_BITS1 = (SUM_BITS0 > POINT_BITS) ? SUM_BITS0 : POINT_BITS;
  localparam int SUM_BITS  = SUM_BITS1 + 1;

  localparam logic [DEC_BITS-1:0] DEC_INIT      = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_STEP_DOWN = DEC_BITS'(10);
  localparam logic [DEC_BITS-1:0] DEC_STEP_FLAT = DEC_BITS'(6);

  localparam logic [OCT_BITS-1:0] OCT_FIRST = '0;
  localparam logic [OCT_BITS-1:0] OCT_LAST  = '1;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

endpackage

/* sv/mcr_if.sv */
// Handshake channels: command items in, point items out.
interface mcr_cmd_if;
  import mcr_pkg::*;
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface mcr_pts_if;
  import mcr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic [OCT_BITS-1:0]          octant;
  logic                         last;
  logic                         circle_done;

  modport source (output valid, point_x, point_y, octant, last, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, octant, last, circle_done, output ready);
endinterface

/* sv/midpoint_circle_rasterizer_top.sv */
// Midpoint circle rasteriser: decision-variable stepper and eight-point octet emitter.
// First point of a drawing step item is presented in the cycle after it is accepted.
// A drawing step item gives eight points, one point per cycle while pts.ready is high;
// start items and non-drawing steps emit none and are taken when no octet is held.
// The next item is taken in the cycle the eighth point of the current octet leaves.
// Reset (synchronous, rst high) clears the circle state and drops any pending octet.
module midpoint_circle_rasterizer_top (
  input logic      clk,
  input logic      rst,
  mcr_cmd_if.sink  cmd,
  mcr_pts_if.source pts
);
  import mcr_pkg::*;

  logic [STEP_BITS-1:0]  step_x, step_x_next;
  logic [STEP_BITS-1:0]  step_y, step_y_next;
  logic [DEC_BITS-1:0]   decision, decision_next;
  logic [COORD_BITS-1:0] held_center_x, held_center_y;
  logic                  active, active_next;

  logic                  oct_valid;
  logic [OCT_BITS-1:0]   cnt;
  logic [COORD_BITS-1:0] oct_cx, oct_cy;
  logic [STEP_BITS-1:0]  oct_x, oct_y;
  logic                  oct_done;

  logic                  accept, emit, pop;
  logic signed [STEP_BITS:0] nx_w, ny_w;
  logic                  done;
  logic [DEC_BITS-1:0]   dec_down, dec_flat;
  logic [SUM_BITS-1:0]   a_off, b_off, px_sum, py_sum;

  assign pop    = oct_valid && pts.ready;
  assign cmd.ready = !oct_valid || (pts.ready && (cnt == OCT_LAST));
  assign accept = cmd.valid && cmd.ready;
  assign emit   = accept && (cmd.kind == KIND_STEP) && active && !(step_x > step_y);

  // decision update, evaluated against the pre-update value
  always_comb begin
    nx_w     = $signed({1'b0, step_x}) + (STEP_BITS+1)'(1);
    dec_down = decision + ((DEC_BITS'(step_x) - DEC_BITS'(step_y)
                            + DEC_BITS'(2)) << 2) + DEC_STEP_DOWN;
    dec_flat = decision + ((DEC_BITS'(step_x) + DEC_BITS'(1)) << 2) + DEC_STEP_FLAT;
    if ($signed(decision) > $signed(DEC_BITS'(0))) begin
      ny_w          = $signed({1'b0, step_y}) - (STEP_BITS+1)'(1);
      decision_next = dec_down;
    end else begin
      ny_w          = $signed({1'b0, step_y});
      decision_next = dec_flat;
    end
    done        = nx_w > ny_w;
    step_x_next = nx_w[STEP_BITS-1:0];
    step_y_next = ny_w[STEP_BITS-1:0];
    active_next = !done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (cmd.kind == KIND_START) begin
        step_x        <= '0;
        step_y        <= STEP_BITS'(cmd.radius);
        decision      <= DEC_INIT - (DEC_BITS'(cmd.radius) << 1);
        held_center_x <= cmd.center_x;
        held_center_y <= cmd.center_y;
        active        <= 1'b1;
      end else if (emit) begin
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
        active   <= active_next;
      end else begin
        active <= 1'b0;
      end
    end
  end

  // octet holding register and point counter
  always_ff @(posedge clk) begin
    if (rst) begin
      oct_valid <= 1'b0;
      cnt       <= OCT_FIRST;
    end else if (emit) begin
      oct_valid <= 1'b1;
      cnt       <= OCT_FIRST;
    end else if (pop) begin
      cnt <= cnt + OCT_BITS'(1);
      if (cnt == OCT_LAST) begin
        oct_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oct_cx   <= held_center_x;
      oct_cy   <= held_center_y;
      oct_x    <= step_x;
      oct_y    <= step_y;
      oct_done <= done;
    end
  end

  // octant bit 2 swaps the offsets, bit 0 negates x, bit 1 negates y
  always_comb begin
    a_off  = cnt[2] ? SUM_BITS'(oct_y) : SUM_BITS'(oct_x);
    b_off  = cnt[2] ? SUM_BITS'(oct_x) : SUM_BITS'(oct_y);
    px_sum = cnt[0] ? SUM_BITS'(oct_cx) - a_off : SUM_BITS'(oct_cx) + a_off;
    py_sum = cnt[1] ? SUM_BITS'(oct_cy) - b_off : SUM_BITS'(oct_cy) + b_off;
  end

  assign pts.valid       = oct_valid;
  assign pts.point_x     = px_sum[POINT_BITS-1:0];
  assign pts.point_y     = py_sum[POINT_BITS-1:0];
  assign pts.octant      = cnt;
  assign pts.last        = (cnt == OCT_LAST);
  assign pts.circle_done = oct_done;

`ifndef SYNTH
  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> step_x <= step_y)
    else $error("active circle with x past y");

  a_emit_loads_octet: assert property (@(posedge clk) disable iff (rst)
    emit |=> oct_valid && cnt == OCT_FIRST)
    else $error("drawing step did not load an octet");

  a_ready_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.ready && oct_valid) |-> (cnt == OCT_LAST && pts.ready))
    else $error("item taken while octet still pending");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (rst)
    (oct_valid && !pts.ready) |=> oct_valid && $stable(cnt))
    else $error("point counter moved during stall");
`endif

endmodule
